FILE: design/apsl_pkg.sv
// apsl_pkg: shared constants for the actuator pulse slew limiter
// no dependencies; imported by apsl_chan and the top level

package apsl_pkg;

    localparam int NUM_CH      = 6;
    localparam int CMD_W       = 16;
    localparam int SAT_W       = 14;
    localparam int PULSE_W     = 11;
    localparam int STEP_W      = 10;
    localparam int CFG_IDX_W   = 8;

    localparam logic [SAT_W-1:0]   CMD_MAX          = 14'd10000;
    localparam logic [PULSE_W-1:0] PULSE_MIN        = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_IDLE_FIRST = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_IDLE_OTHER = 11'd1500;
    localparam logic [STEP_W-1:0]  STEP_RESET       = 10'd1;

    // ceil(2^16 / 10); exact floor(x / 10) for x in 0..10000
    localparam int RECIP_W = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_DIV10 = 13'd6554;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP_UP   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP_DOWN = 8'd1;

    typedef logic [PULSE_W-1:0] pulse_t;
    typedef logic [STEP_W-1:0]  step_t;

endpackage

FILE: design/apsl_chan.sv
// apsl_chan: one channel of command saturation, pulse mapping and slew limit
// depends on apsl_pkg

module apsl_chan
    import apsl_pkg::*;
(
    input  logic signed [CMD_W-1:0] command,
    input  pulse_t                  prev,
    input  step_t                   step_up,
    input  step_t                   step_down,
    output pulse_t                  pulse
);

    logic [SAT_W-1:0]           cmd_sat;
    logic [SAT_W+RECIP_W-1:0]   prod;
    logic [STEP_W-1:0]          quot;
    pulse_t                     width;
    logic signed [PULSE_W+1:0]  diff;
    logic signed [PULSE_W+1:0]  up_s;
    logic signed [PULSE_W+1:0]  down_s;

    // saturate to 0..10000
    always_comb
    begin
        if (command[CMD_W-1])
        begin
            cmd_sat = '0;
        end
        else if (command[CMD_W-2:0] > 15'(CMD_MAX))
        begin
            cmd_sat = CMD_MAX;
        end
        else
        begin
            cmd_sat = command[SAT_W-1:0];
        end
    end

    // divide by ten through reciprocal multiply; result is 0..1000
    assign prod  = (SAT_W+RECIP_W)'(cmd_sat) * (SAT_W+RECIP_W)'(RECIP_DIV10);
    assign quot  = prod[RECIP_SHIFT+STEP_W-1:RECIP_SHIFT];
    // 1000..2000, so no range clamp is needed
    assign width = PULSE_MIN + PULSE_W'(quot);

    assign diff   = $signed({2'b00, width}) - $signed({2'b00, prev});
    assign up_s   = $signed({3'b000, step_up});
    assign down_s = $signed({3'b000, step_down});

    // once the up limit acts the down test cannot fire
    always_comb
    begin
        priority if (diff > up_s)
        begin
            pulse = prev + PULSE_W'(step_up);
        end
        else if (diff < -down_s)
        begin
            pulse = prev - PULSE_W'(step_down);
        end
        else
        begin
            pulse = width;
        end
    end

endmodule

FILE: design/actuator_pulse_slew_limiter_unit.sv
// actuator_pulse_slew_limiter_unit: six-channel pulse mapper with slew limit
// depends on apsl_pkg and apsl_chan
//
// a word accepted into the input register moves into the result register when that can load
// throughput: one word per cycle while out_stall is low; an input register and a result
// register decouple the channels, the per-channel limit logic sits between them
// reset: step limits go to 1, stored widths to 1000 (channel 0) / 1500 (others)

module actuator_pulse_slew_limiter_unit
    import apsl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    // input word channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      motors_enabled,
    input  logic signed [CMD_W-1:0]   command_0,
    input  logic signed [CMD_W-1:0]   command_1,
    input  logic signed [CMD_W-1:0]   command_2,
    input  logic signed [CMD_W-1:0]   command_3,
    input  logic signed [CMD_W-1:0]   command_4,
    input  logic signed [CMD_W-1:0]   command_5,

    // result word channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output pulse_t                    pulse_0,
    output pulse_t                    pulse_1,
    output pulse_t                    pulse_2,
    output pulse_t                    pulse_3,
    output pulse_t                    pulse_4,
    output pulse_t                    pulse_5,

    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [STEP_W-1:0]         cfg_data
);

    // configuration registers
    step_t step_up_reg;
    step_t step_down_reg;

    // input register
    logic                     in_valid_reg;
    logic                     enabled_reg;
    logic signed [CMD_W-1:0]  cmd_reg [NUM_CH];

    // result register and per-channel history
    logic                     out_valid_reg;
    pulse_t                   pulse_reg      [NUM_CH];
    pulse_t                   last_pulse_reg [NUM_CH];

    pulse_t                   limited   [NUM_CH];
    pulse_t                   idle_w    [NUM_CH];
    logic signed [CMD_W-1:0]  cmd_in    [NUM_CH];

    logic out_advance;
    logic in_take;

    // result register can load when empty or being drained
    assign out_advance = !out_valid_reg || !out_stall;
    // input register frees up whenever its word moves on
    assign in_stall    = in_valid_reg && !out_advance;
    assign in_take     = in_valid && !in_stall;

    assign cfg_ready   = 1'b1;

    assign cmd_in[0] = command_0;
    assign cmd_in[1] = command_1;
    assign cmd_in[2] = command_2;
    assign cmd_in[3] = command_3;
    assign cmd_in[4] = command_4;
    assign cmd_in[5] = command_5;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_up_reg   <= STEP_RESET;
            step_down_reg <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MAX_STEP_UP)
            begin
                step_up_reg <= cfg_data;
            end
            if (cfg_index == REG_MAX_STEP_DOWN)
            begin
                step_down_reg <= cfg_data;
            end
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (out_advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            enabled_reg <= motors_enabled;
            for (int i = 0; i < NUM_CH; i++)
            begin
                cmd_reg[i] <= cmd_in[i];
            end
        end
    end

    // per-channel limit logic
    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_chan
        apsl_chan u_chan (
            .command   (cmd_reg[g]),
            .prev      (last_pulse_reg[g]),
            .step_up   (step_up_reg),
            .step_down (step_down_reg),
            .pulse     (limited[g])
        );

        // channel 0 idles low, the rest idle at mid scale
        assign idle_w[g] = (g == 0) ? PULSE_IDLE_FIRST : PULSE_IDLE_OTHER;
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // history only moves on enabled words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                last_pulse_reg[i] <= (i == 0) ? PULSE_IDLE_FIRST : PULSE_IDLE_OTHER;
            end
        end
        else if (out_advance && in_valid_reg && enabled_reg)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                last_pulse_reg[i] <= limited[i];
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                pulse_reg[i] <= enabled_reg ? limited[i] : idle_w[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pulse_0   = pulse_reg[0];
    assign pulse_1   = pulse_reg[1];
    assign pulse_2   = pulse_reg[2];
    assign pulse_3   = pulse_reg[3];
    assign pulse_4   = pulse_reg[4];
    assign pulse_5   = pulse_reg[5];

endmodule
